// ----- rtl/mjdbcd_pkg.sv -----
// ============================================================================
// mjdbcd_pkg
// Shared constants, types and constant tables for the MJD/BCD time decoder.
// ============================================================================
package mjdbcd_pkg;

    localparam int unsigned CODE_W    = 40;
    localparam int unsigned MJD_W     = 16;
    localparam int unsigned N_W       = 20;   // scaled date numerator
    localparam int unsigned YP_W      = 8;    // years since 1900 (before march carry)
    localparam int unsigned REM_W     = 9;    // days since the shifted year start
    localparam int unsigned MP_W      = 4;    // shifted month index
    localparam int unsigned BCD_W     = 8;
    localparam int unsigned DUR_W     = 20;
    localparam int unsigned YEAR_W    = 11;
    localparam int unsigned MONTH_W   = 4;
    localparam int unsigned DAY_W     = 5;

    localparam logic [CODE_W-1:0] CODE_UNKNOWN = {CODE_W{1'b1}};

    localparam logic [MJD_W-1:0]  MJD_MIN      = 16'd15079;
    localparam logic [N_W:0]      N_BIAS       = 21'd301564;  // 20 * 15078.2
    localparam logic [N_W-1:0]    YEAR_DIV     = 20'd7305;    // 20 * 365.25
    // floor(2^32 / 7305), so the estimate never overshoots
    localparam logic [N_W-1:0]    YEAR_RECIP   = 20'd587948;
    localparam int unsigned       RECIP_SHIFT  = 32;
    localparam logic [17:0]       DAYS_4Y      = 18'd1461;
    localparam logic [16:0]       MJD_BASE     = 17'd14956;
    localparam logic [YEAR_W-1:0] YEAR_BASE    = 11'd1900;
    localparam int unsigned       MP_MAX       = 15;

    // operation codes
    typedef enum logic {
        OP_START    = 1'b0,
        OP_DURATION = 1'b1
    } op_t;

    // per-item control that rides along the pipeline
    typedef struct packed {
        logic op_dur;
        logic unknown;
        logic out_range;
    } ctl_t;

    // smallest day offset at which the month index reaches k:
    // ceil((306001*k + 1000) / 10000)
    function automatic logic [REM_W-1:0] month_thr(input int unsigned k);
        int unsigned v;
        v = (306001 * k + 1000 + 9999) / 10000;
        return REM_W'(v);
    endfunction

    // floor(k * 30.6001)
    function automatic logic [REM_W-1:0] month_off(input logic [MP_W-1:0] k);
        int unsigned v;
        v = (306001 * int'(k)) / 10000;
        return REM_W'(v);
    endfunction

    // packed bcd byte to binary, invalid nibbles passed through arithmetically
    function automatic logic [BCD_W-1:0] bcd_to_bin(input logic [7:0] b);
        return BCD_W'({4'd0, b[7:4]} * 8'd10 + {4'd0, b[3:0]});
    endfunction

endpackage

// ----- rtl/mjd_bcd_time_decoder.sv -----
// ============================================================================
// mjd_bcd_time_decoder
// Broadcast time code decoder: MJD + BCD start times and BCD durations.
// ============================================================================
//
// usage
//   request in : s_valid / s_ready, s_operation selects start time (0) or
//                duration (1), s_time_code holds MJD[39:24] and BCD hh mm ss
//   result out : m_valid / m_ready, one result per request, in order
//   throughput : one request per cycle while m_ready does not stall the output;
//                the year divide is a reciprocal multiply plus one correction,
//                the month divide a threshold compare, each in its own stage
//   stages     : bcd/scale -> reciprocal multiply -> correction -> year start
//                -> month index -> date assembly into the output register
//   reset      : aresetn (synchronous, active low) clears all stage valid bits;
//                payload registers hold whatever they had
//   stall      : when m_ready is low the result holds, and each stage keeps
//                accepting until it runs into a full stage ahead of it, so
//                bubbles get squeezed out before s_ready drops
//   special    : an all-ones start code flags unknown_time with zero fields;
//                MJD below 15079 flags out_of_range with a zero date
//
module mjd_bcd_time_decoder
    import mjdbcd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_operation,
    input  logic [CODE_W-1:0]     s_time_code,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_unknown_time,
    output logic                  m_out_of_range,
    output logic [YEAR_W-1:0]     m_year,
    output logic [MONTH_W-1:0]    m_month,
    output logic [DAY_W-1:0]      m_day,
    output logic [BCD_W-1:0]      m_hour,
    output logic [BCD_W-1:0]      m_minute,
    output logic [BCD_W-1:0]      m_second,
    output logic [DUR_W-1:0]      m_duration_seconds
);

    // ---------------- handshake: per-stage enables ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic en1, en2, en3, en4, en5, en6;

    // a stage loads when it is empty or the stage ahead is loading
    assign en6 = !v6_reg || m_ready;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
        end
    end

    // ---------------- stage 1: bcd decode, flags, scaled numerator ----------------
    ctl_t               ctl1_next, ctl1_reg;
    logic [MJD_W-1:0]   mjd1_next, mjd1_reg;
    logic [N_W-1:0]     n1_next, n1_reg;
    logic [BCD_W-1:0]   hh1_next, mm1_next, ss1_next;
    logic [BCD_W-1:0]   hh1_reg, mm1_reg, ss1_reg;
    logic [N_W:0]       n1_wide;

    always_comb begin
        mjd1_next         = s_time_code[39:24];
        ctl1_next.op_dur  = (op_t'(s_operation) == OP_DURATION);
        ctl1_next.unknown = !ctl1_next.op_dur && (s_time_code == CODE_UNKNOWN);
        ctl1_next.out_range = !ctl1_next.op_dur && !ctl1_next.unknown
                            && (mjd1_next < MJD_MIN);
        // 20*mjd - 301564, only meaningful for in-range dates
        n1_wide   = ((N_W+1)'(mjd1_next) * (N_W+1)'(20)) - N_BIAS;
        n1_next   = n1_wide[N_W-1:0];
        hh1_next  = bcd_to_bin(s_time_code[23:16]);
        mm1_next  = bcd_to_bin(s_time_code[15:8]);
        ss1_next  = bcd_to_bin(s_time_code[7:0]);
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            ctl1_reg <= ctl1_next;
            mjd1_reg <= mjd1_next;
            n1_reg   <= n1_next;
            hh1_reg  <= hh1_next;
            mm1_reg  <= mm1_next;
            ss1_reg  <= ss1_next;
        end
    end

    // ---------------- stage 2: reciprocal multiply, duration sum ----------------
    ctl_t               ctl2_reg;
    logic [MJD_W-1:0]   mjd2_reg;
    logic [N_W-1:0]     n2_reg;
    logic [BCD_W-1:0]   hh2_reg, mm2_reg, ss2_reg;
    logic [YP_W-1:0]    q2_next, q2_reg;
    logic [DUR_W-1:0]   dur2_next, dur2_reg;
    logic [2*N_W-1:0]   recip_prod;

    always_comb begin
        recip_prod = (2*N_W)'(n1_reg) * (2*N_W)'(YEAR_RECIP);
        q2_next    = recip_prod[RECIP_SHIFT +: YP_W];
        dur2_next  = (DUR_W'(hh1_reg) * DUR_W'(3600))
                   + (DUR_W'(mm1_reg) * DUR_W'(60))
                   + DUR_W'(ss1_reg);
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            ctl2_reg <= ctl1_reg;
            mjd2_reg <= mjd1_reg;
            n2_reg   <= n1_reg;
            hh2_reg  <= hh1_reg;
            mm2_reg  <= mm1_reg;
            ss2_reg  <= ss1_reg;
            q2_reg   <= q2_next;
            dur2_reg <= dur2_next;
        end
    end

    // ---------------- stage 3: quotient correction ----------------
    ctl_t               ctl3_reg;
    logic [MJD_W-1:0]   mjd3_reg;
    logic [BCD_W-1:0]   hh3_reg, mm3_reg, ss3_reg;
    logic [DUR_W-1:0]   dur3_reg;
    logic [YP_W-1:0]    yp3_next, yp3_reg;
    logic [N_W-1:0]     r3;

    always_comb begin
        // estimate is exact or one low
        r3 = n2_reg - (N_W'(q2_reg) * YEAR_DIV);
        yp3_next = (r3 >= YEAR_DIV) ? q2_reg + YP_W'(1) : q2_reg;
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            ctl3_reg <= ctl2_reg;
            mjd3_reg <= mjd2_reg;
            hh3_reg  <= hh2_reg;
            mm3_reg  <= mm2_reg;
            ss3_reg  <= ss2_reg;
            dur3_reg <= dur2_reg;
            yp3_reg  <= yp3_next;
        end
    end

    // ---------------- stage 4: day offset into the shifted year ----------------
    ctl_t               ctl4_reg;
    logic [BCD_W-1:0]   hh4_reg, mm4_reg, ss4_reg;
    logic [DUR_W-1:0]   dur4_reg;
    logic [YP_W-1:0]    yp4_reg;
    logic [REM_W-1:0]   rem4_next, rem4_reg;
    logic [17:0]        yd4;
    logic [16:0]        rem4_wide;

    always_comb begin
        yd4       = 18'(yp3_reg) * DAYS_4Y;
        rem4_wide = 17'(mjd3_reg) - MJD_BASE - 17'(yd4[17:2]);
        rem4_next = rem4_wide[REM_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            ctl4_reg <= ctl3_reg;
            hh4_reg  <= hh3_reg;
            mm4_reg  <= mm3_reg;
            ss4_reg  <= ss3_reg;
            dur4_reg <= dur3_reg;
            yp4_reg  <= yp3_reg;
            rem4_reg <= rem4_next;
        end
    end

    // ---------------- stage 5: month index by threshold compare ----------------
    ctl_t               ctl5_reg;
    logic [BCD_W-1:0]   hh5_reg, mm5_reg, ss5_reg;
    logic [DUR_W-1:0]   dur5_reg;
    logic [YP_W-1:0]    yp5_reg;
    logic [REM_W-1:0]   rem5_reg;
    logic [MP_W-1:0]    mp5_next, mp5_reg;
    logic [MP_MAX-1:0]  mp_ge;

    always_comb begin
        for (int k = 1; k <= MP_MAX; k++) begin
            mp_ge[k-1] = (rem4_reg >= month_thr(k));
        end
        mp5_next = MP_W'($countones(mp_ge));
    end

    always_ff @(posedge aclk) begin
        if (en5) begin
            ctl5_reg <= ctl4_reg;
            hh5_reg  <= hh4_reg;
            mm5_reg  <= mm4_reg;
            ss5_reg  <= ss4_reg;
            dur5_reg <= dur4_reg;
            yp5_reg  <= yp4_reg;
            rem5_reg <= rem4_reg;
            mp5_reg  <= mp5_next;
        end
    end

    // ---------------- stage 6: date assembly, output register ----------------
    logic                unk6_next, oor6_next;
    logic [YEAR_W-1:0]   year6_next;
    logic [MONTH_W-1:0]  month6_next;
    logic [DAY_W-1:0]    day6_next;
    logic [BCD_W-1:0]    hh6_next, mm6_next, ss6_next;
    logic [DUR_W-1:0]    dur6_next;
    logic                jan_feb;
    logic                date_ok;
    logic [REM_W-1:0]    day_wide;

    always_comb begin
        // january and february belong to the following calendar year
        jan_feb  = (mp5_reg == MP_W'(14)) || (mp5_reg == MP_W'(15));
        date_ok  = !ctl5_reg.op_dur && !ctl5_reg.unknown && !ctl5_reg.out_range;
        day_wide = rem5_reg - month_off(mp5_reg);

        unk6_next   = ctl5_reg.unknown;
        oor6_next   = ctl5_reg.out_range;
        year6_next  = '0;
        month6_next = '0;
        day6_next   = '0;
        if (date_ok) begin
            year6_next  = YEAR_BASE + YEAR_W'(yp5_reg) + YEAR_W'(jan_feb);
            month6_next = jan_feb ? mp5_reg - MONTH_W'(13) : mp5_reg - MONTH_W'(1);
            day6_next   = day_wide[DAY_W-1:0];
        end
        hh6_next  = ctl5_reg.unknown ? '0 : hh5_reg;
        mm6_next  = ctl5_reg.unknown ? '0 : mm5_reg;
        ss6_next  = ctl5_reg.unknown ? '0 : ss5_reg;
        dur6_next = ctl5_reg.op_dur ? dur5_reg : '0;
    end

    logic                unk6_reg, oor6_reg;
    logic [YEAR_W-1:0]   year6_reg;
    logic [MONTH_W-1:0]  month6_reg;
    logic [DAY_W-1:0]    day6_reg;
    logic [BCD_W-1:0]    hh6_reg, mm6_reg, ss6_reg;
    logic [DUR_W-1:0]    dur6_reg;

    always_ff @(posedge aclk) begin
        if (en6) begin
            unk6_reg   <= unk6_next;
            oor6_reg   <= oor6_next;
            year6_reg  <= year6_next;
            month6_reg <= month6_next;
            day6_reg   <= day6_next;
            hh6_reg    <= hh6_next;
            mm6_reg    <= mm6_next;
            ss6_reg    <= ss6_next;
            dur6_reg   <= dur6_next;
        end
    end

    assign m_valid            = v6_reg;
    assign m_unknown_time     = unk6_reg;
    assign m_out_of_range     = oor6_reg;
    assign m_year             = year6_reg;
    assign m_month            = month6_reg;
    assign m_day              = day6_reg;
    assign m_hour             = hh6_reg;
    assign m_minute           = mm6_reg;
    assign m_second           = ss6_reg;
    assign m_duration_seconds = dur6_reg;

    // ---------------- assertions ----------------
`ifndef SYNTHESIS
    // input only backs up once every stage is full and the output is stalled
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && v1_reg && v2_reg && v3_reg
                      && v4_reg && v5_reg))
        else $error("s_ready low with room in the pipeline");

    // the two flags never come together
    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_unknown_time && m_out_of_range))
        else $error("unknown and out-of-range both set");

    // unknown start code zeroes every field; the check covers date, hour and duration
    a_unknown_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_unknown_time) |-> (m_year == '0 && m_month == '0
            && m_day == '0 && m_hour == '0 && m_duration_seconds == '0))
        else $error("unknown start code with nonzero fields");

    // a decoded date has a legal month and day and a zero duration
    a_date_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_year != '0) |-> (m_month >= MONTH_W'(1)
            && m_month <= MONTH_W'(12) && m_day >= DAY_W'(1)
            && m_duration_seconds == '0))
        else $error("decoded date out of calendar range");
`endif

endmodule

// ----- tb/tb_mjd_bcd_time_decoder.sv -----
// ============================================================================
// tb_mjd_bcd_time_decoder
// Self-checking bench for the MJD/BCD broadcast time decoder. Start-time and
// duration requests are sent through a valid/ready driver with random gaps.
// Each accepted request is decoded by an exact integer model of the calendar
// formula. A monitor with random back-pressure compares every result field
// against the oldest prediction.
// ============================================================================
module tb_mjd_bcd_time_decoder;
    import mjdbcd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // run limits and traffic shape
    localparam int unsigned N_RANDOM     = 1150;
    localparam int unsigned LIMIT_CYCLES = 200000;
    localparam int unsigned IDLE_PCT     = 24;
    localparam int unsigned CALM_FIRST   = 500;   // no idling on either side
    localparam int unsigned CALM_LAST    = 800;   // for this span of requests
    localparam int unsigned DRAIN_CYCLES = 16;    // six-stage pipe plus margin

    // integer form of the calendar formula (scaled by 20 and 10000)
    localparam longint unsigned YEAR_NUM_BIAS = 301564;
    localparam longint unsigned YEAR_DEN      = 7305;
    localparam longint unsigned DAYS_PER_4Y   = 1461;
    localparam longint unsigned MJD_EPOCH     = 14956;
    localparam longint unsigned MONTH_DEN     = 306001;
    localparam longint unsigned MONTH_SCALE   = 10000;
    localparam longint unsigned MONTH_BIAS    = 1000;
    localparam longint unsigned BASE_YEAR     = 1900;

    // one request as it travels on the input channel
    typedef struct packed {
        op_t               op;
        logic [CODE_W-1:0] code;
    } time_request_t;

    // one decoded result
    typedef struct packed {
        logic               unknown_time;
        logic               out_of_range;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [BCD_W-1:0]   hour;
        logic [BCD_W-1:0]   minute;
        logic [BCD_W-1:0]   second;
        logic [DUR_W-1:0]   duration_seconds;
    } time_result_t;

    // ------------------------------------------------------------------------
    // clock, reset and dut ports (all inputs known from time zero)
    // ------------------------------------------------------------------------
    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    logic                s_operation = 1'b0;
    logic [CODE_W-1:0]   s_time_code = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    logic                m_unknown_time;
    logic                m_out_of_range;
    logic [YEAR_W-1:0]   m_year;
    logic [MONTH_W-1:0]  m_month;
    logic [DAY_W-1:0]    m_day;
    logic [BCD_W-1:0]    m_hour;
    logic [BCD_W-1:0]    m_minute;
    logic [BCD_W-1:0]    m_second;
    logic [DUR_W-1:0]    m_duration_seconds;

    // bench bookkeeping
    time_request_t pending_codes[$];     // requests not yet offered
    time_result_t  predicted_times[$];   // decodes waiting for their result
    int unsigned   n_requests  = 0;
    int unsigned   n_sent      = 0;
    int unsigned   n_accepted  = 0;
    int unsigned   n_checked   = 0;
    int unsigned   error_count = 0;
    int unsigned   cycle_count = 0;

    always #5 aclk = ~aclk;

    mjd_bcd_time_decoder u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_operation        (s_operation),
        .s_time_code        (s_time_code),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_unknown_time     (m_unknown_time),
        .m_out_of_range     (m_out_of_range),
        .m_year             (m_year),
        .m_month            (m_month),
        .m_day              (m_day),
        .m_hour             (m_hour),
        .m_minute           (m_minute),
        .m_second           (m_second),
        .m_duration_seconds (m_duration_seconds)
    );

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // packed bcd byte to its value, nibbles above nine kept as they are
    function automatic logic [BCD_W-1:0] bcd_value(input logic [7:0] b);
        return BCD_W'(b[7:4] * 10 + b[3:0]);
    endfunction

    // two-digit value to packed bcd
    function automatic logic [7:0] to_bcd(input int unsigned v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    function automatic logic [CODE_W-1:0] start_code(input int unsigned mjd,
                                                     input int unsigned hh,
                                                     input int unsigned mm,
                                                     input int unsigned ss);
        return {16'(mjd), to_bcd(hh), to_bcd(mm), to_bcd(ss)};
    endfunction

    // append one request to the pending queue
    task automatic queue_request(input op_t op, input logic [CODE_W-1:0] code);
        time_request_t req;
        req.op   = op;
        req.code = code;
        pending_codes.insert(pending_codes.size(), req);
    endtask

    function automatic time_result_t decode_time_code(input time_request_t req);
        time_result_t    res;
        longint unsigned mjd, yp, yr_start, rem, mp, mon_start, carry;
        res        = '0;
        res.hour   = bcd_value(req.code[23:16]);
        res.minute = bcd_value(req.code[15:8]);
        res.second = bcd_value(req.code[7:0]);
        if (req.op == OP_DURATION) begin
            // bcd duration, date fields stay zero
            res.duration_seconds = DUR_W'(64'(res.hour) * 3600 + 64'(res.minute) * 60
                                          + 64'(res.second));
        end else if (req.code == CODE_UNKNOWN) begin
            // undefined start time: flag only, everything else zero
            res              = '0;
            res.unknown_time = 1'b1;
        end else begin
            mjd = 64'(req.code[39:24]);
            if (mjd < 64'(MJD_MIN)) begin
                res.out_of_range = 1'b1;
            end else begin
                yp        = (mjd * 20 - YEAR_NUM_BIAS) / YEAR_DEN;
                yr_start  = (yp * DAYS_PER_4Y) >> 2;
                rem       = mjd - MJD_EPOCH - yr_start;
                mp        = (rem * MONTH_SCALE - MONTH_BIAS) / MONTH_DEN;
                mon_start = (mp * MONTH_DEN) / MONTH_SCALE;
                // months 14 and 15 are january and february of the next year
                carry     = (mp == 14 || mp == 15) ? 1 : 0;
                res.year  = YEAR_W'(BASE_YEAR + yp + carry);
                res.month = MONTH_W'(mp - 1 - 12 * carry);
                res.day   = DAY_W'(rem - mon_start);
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // driver: offers pending requests, predicts each one it gets accepted
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        time_request_t accepted;
        time_request_t next_req;
        logic          calm;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                accepted.op   = op_t'(s_operation);
                accepted.code = s_time_code;
                predicted_times.insert(predicted_times.size(),
                                       decode_time_code(accepted));
                n_accepted++;
            end
            calm = (n_sent >= CALM_FIRST && n_sent < CALM_LAST);
            // a new request may go out once the current one is taken
            if (!s_valid || s_ready) begin
                if (pending_codes.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    next_req = pending_codes.pop_front();
                    s_valid     <= 1'b1;
                    s_operation <= next_req.op;
                    s_time_code <= next_req.code;
                    n_sent++;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: random back-pressure, field by field compare
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $error("%s expected %0d actual %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        time_result_t want;
        logic         calm;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_times.size() == 0) begin
                    $error("result with no request outstanding");
                    error_count++;
                end else begin
                    want = predicted_times.pop_front();
                    check_field("unknown_time", want.unknown_time, m_unknown_time);
                    check_field("out_of_range", want.out_of_range, m_out_of_range);
                    check_field("year", want.year, m_year);
                    check_field("month", want.month, m_month);
                    check_field("day", want.day, m_day);
                    check_field("hour", want.hour, m_hour);
                    check_field("minute", want.minute, m_minute);
                    check_field("second", want.second, m_second);
                    check_field("duration_seconds", want.duration_seconds,
                                m_duration_seconds);
                end
                n_checked++;
            end
            calm = (n_checked >= CALM_FIRST && n_checked < CALM_LAST);
            m_ready <= calm || $urandom_range(99) >= IDLE_PCT;
        end
    end

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        time_request_t req;
        int unsigned   mjd;
        int unsigned   pick;
        logic [23:0]   hms;

        // directed: range edges, flags, calendar corners, bad bcd
        queue_request(OP_START, 40'h0);                           // mjd zero
        queue_request(OP_START, start_code(15078, 23, 59, 59));   // last out of range
        queue_request(OP_START, start_code(15079, 0, 0, 0));      // first valid date
        queue_request(OP_START, start_code(15384, 12, 30, 45));   // end of 1900
        queue_request(OP_START, start_code(15385, 1, 2, 3));      // new year 1901
        queue_request(OP_START, start_code(15444, 6, 7, 8));      // march 1901
        queue_request(OP_START, start_code(51543, 23, 59, 59));   // end of 1999
        queue_request(OP_START, start_code(51544, 0, 0, 0));      // start of 2000
        queue_request(OP_START, start_code(51603, 11, 11, 11));   // leap day 2000
        queue_request(OP_START, start_code(51604, 22, 22, 22));   // march 2000
        queue_request(OP_START, start_code(65535, 23, 59, 59));   // top mjd
        queue_request(OP_START, CODE_UNKNOWN);                    // undefined time
        queue_request(OP_START, 40'hFF_FFFF_FFFE);                // one bit off
        queue_request(OP_START, 40'h3AE7_A5F0_9C);                // bad bcd nibbles
        queue_request(OP_START, 40'h3AE7_FFFF_FF);
        queue_request(OP_START, 40'h0000_FFFF_FF);                // bad bcd, no date
        queue_request(OP_DURATION, 40'h0);
        queue_request(OP_DURATION, CODE_UNKNOWN);                 // largest duration
        queue_request(OP_DURATION, 40'hABCD_2359_59);
        queue_request(OP_DURATION, 40'h5555_9999_99);
        queue_request(OP_DURATION, 40'h0000_0000_01);

        // random: mostly well-formed start times, some durations and noise
        repeat (N_RANDOM) begin
            pick = $urandom_range(99);
            if ($urandom_range(99) < 75)
                hms = {to_bcd($urandom_range(23)), to_bcd($urandom_range(59)),
                       to_bcd($urandom_range(59))};
            else if ($urandom_range(1) == 0)
                hms = {to_bcd($urandom_range(99)), to_bcd($urandom_range(99)),
                       to_bcd($urandom_range(99))};
            else
                hms = 24'($urandom);
            if (pick < 25) begin
                req.op   = OP_DURATION;
                req.code = {16'($urandom), hms};
                if ($urandom_range(29) == 0)
                    req.code = CODE_UNKNOWN;
            end else begin
                req.op = OP_START;
                if (pick < 80)
                    mjd = $urandom_range(65535, 15079);
                else if (pick < 87)
                    mjd = $urandom_range(15078, 0);
                else
                    mjd = $urandom_range(15090, 15070);   // around the range limit
                req.code = {16'(mjd), hms};
                if (pick >= 92 && pick < 96)
                    req.code = CODE_UNKNOWN;
                else if (pick >= 96)
                    req.code = {8'($urandom), 32'($urandom)};
            end
            pending_codes.insert(pending_codes.size(), req);
        end
        n_requests = pending_codes.size();

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // sampled away from the active edge to stay clear of the driver
        while (n_accepted < n_requests || predicted_times.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
